>>> src/jse_pkg.sv
// Shared types and character constants for the JSON string escaper.
`timescale 1ns / 1ps
package jse_pkg;

   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5c;
   localparam logic [7:0] CH_U      = 8'h75;
   localparam logic [7:0] CH_B      = 8'h62;
   localparam logic [7:0] CH_F      = 8'h66;
   localparam logic [7:0] CH_N      = 8'h6e;
   localparam logic [7:0] CH_R      = 8'h72;
   localparam logic [7:0] CH_T      = 8'h74;

   localparam logic [20:0] CODE_MAX     = 21'h10ffff;
   localparam logic [20:0] CODE_PLANE1  = 21'h010000;
   localparam logic [20:0] CODE_CTRL    = 21'h00001f;
   localparam logic [20:0] CODE_ASCII   = 21'h00007f;
   localparam logic [20:0] CODE_BMP     = 21'h00ffff;
   localparam logic [15:0] SURR_HIGH    = 16'hd800;
   localparam logic [15:0] SURR_LOW     = 16'hdc00;

   localparam int ENC_BYTES = 12;
   localparam int JOB_BYTES = 13;

   // Text for one decoded code point.
   typedef struct packed {
      logic [ENC_BYTES-1:0][7:0] bytes;
      logic [3:0]                count;
      logic                      bad;
   } enc_type;

   // Result bytes caused by one accepted item.
   typedef struct packed {
      logic [JOB_BYTES-1:0][7:0] bytes;
      logic [3:0]                last_index;
      logic                      bad;
      logic                      closed;
   } job_type;

endpackage

>>> src/jse_encode.sv
// Turns one code point into its JSON text bytes.
`timescale 1ns / 1ps
module jse_encode import jse_pkg::*; (
   input  logic [20:0] code,
   output enc_type     enc
);

   localparam logic [15:0][7:0] HEX_DIGITS = {
      8'h66, 8'h65, 8'h64, 8'h63, 8'h62, 8'h61, 8'h39, 8'h38,
      8'h37, 8'h36, 8'h35, 8'h34, 8'h33, 8'h32, 8'h31, 8'h30
   };

   function automatic logic [5:0][7:0] u16_escape(input logic [15:0] v);
      logic [5:0][7:0] r;
      r[0] = CH_BSLASH;
      r[1] = CH_U;
      r[2] = HEX_DIGITS[v[15:12]];
      r[3] = HEX_DIGITS[v[11:8]];
      r[4] = HEX_DIGITS[v[7:4]];
      r[5] = HEX_DIGITS[v[3:0]];
      return r;
   endfunction

   logic [7:0]  esc;
   logic [20:0] offset;

   assign offset = code - CODE_PLANE1;

   always_comb begin
      case (code)
         21'h08:  esc = CH_B;
         21'h0c:  esc = CH_F;
         21'h0a:  esc = CH_N;
         21'h0d:  esc = CH_R;
         21'h09:  esc = CH_T;
         21'h22:  esc = CH_QUOTE;
         21'h5c:  esc = CH_BSLASH;
         default: esc = 8'h00;
      endcase
   end

   always_comb begin
      enc       = '0;
      if (esc != 8'h00) begin
         enc.bytes[0] = CH_BSLASH;
         enc.bytes[1] = esc;
         enc.count    = 4'd2;
      end else if (code <= CODE_CTRL) begin
         enc.bytes[5:0] = u16_escape(code[15:0]);
         enc.count      = 4'd6;
      end else if (code <= CODE_ASCII) begin
         enc.bytes[0] = code[7:0];
         enc.count    = 4'd1;
      end else if (code <= CODE_BMP) begin
         enc.bytes[5:0] = u16_escape(code[15:0]);
         enc.count      = 4'd6;
      end else if (code <= CODE_MAX) begin
         enc.bytes[5:0]  = u16_escape(SURR_HIGH | {6'd0, offset[19:10]});
         enc.bytes[11:6] = u16_escape(SURR_LOW | {6'd0, offset[9:0]});
         enc.count       = 4'd12;
      end else begin
         enc.count = 4'd1;
         enc.bad   = 1'b1;
      end
   end

endmodule

>>> src/json_string_escaper.sv
// Top level: UTF-8 decode state, result register and output sequencer.
`timescale 1ns / 1ps
// Takes the UTF-8 bytes of a string, one per transfer, closed by an item with
// req_string_end set, and returns quoted JSON ASCII text, one byte per
// transfer. An item is decoded in the cycle it is accepted and its result
// bytes (up to 13) are loaded into one result register; the block then sends
// one byte per cycle when rsp_ready is high. With one output byte lane, an
// item holds the input until its last byte transfers; one that yields none
// (a lead or inner continuation byte) holds nothing, so plain ASCII streams
// at that rate too. A new item is taken in the cycle the last byte of the
// previous one transfers. An error result has rsp_bad_utf8 set and a zero
// byte; later bytes are dropped up to the end marker, which gives nothing.
module json_string_escaper import jse_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_string_end,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_run_last,
   output logic       rsp_bad_utf8,
   output logic       rsp_string_closed
);

   logic [20:0] partial_ff, partial_in;
   logic [1:0]  pending_ff, pending_in;
   logic        opened_ff, opened_in;
   logic        skip_ff, skip_in;
   logic        busy_ff, busy_in;
   logic [3:0]  idx_ff, idx_in;
   job_type     job_ff, job_in;

   logic [20:0] code;
   logic        do_emit;
   logic        prefix;
   enc_type     enc;
   logic [3:0]  count;
   logic        accept, load, last, rsp_xfer;

   jse_encode u_encode (
      .code (code),
      .enc  (enc)
   );

   assign code = (pending_ff == 2'd0) ? {13'd0, req_data_byte}
                                      : {partial_ff[14:0], req_data_byte[5:0]};

   always_comb begin
      partial_in = partial_ff;
      pending_in = pending_ff;
      opened_in  = opened_ff;
      skip_in    = skip_ff;
      do_emit    = 1'b0;
      prefix     = 1'b0;
      job_in     = '0;
      count      = 4'd0;
      if (req_string_end) begin
         if (!skip_ff) begin
            if (pending_ff != 2'd0) begin
               job_in.bad = 1'b1;
               count      = 4'd1;
            end else if (!opened_ff) begin
               job_in.bytes[0] = CH_QUOTE;
               job_in.bytes[1] = CH_QUOTE;
               job_in.closed   = 1'b1;
               count           = 4'd2;
            end else begin
               job_in.bytes[0] = CH_QUOTE;
               job_in.closed   = 1'b1;
               count           = 4'd1;
            end
         end
         partial_in = '0;
         pending_in = 2'd0;
         opened_in  = 1'b0;
         skip_in    = 1'b0;
      end else if (!skip_ff) begin
         prefix    = !opened_ff;
         opened_in = 1'b1;
         if (pending_ff == 2'd0) begin
            if (req_data_byte[7] == 1'b0) begin
               do_emit = 1'b1;
            end else if (req_data_byte[7:5] == 3'b110) begin
               partial_in = {16'd0, req_data_byte[4:0]};
               pending_in = 2'd1;
            end else if (req_data_byte[7:4] == 4'b1110) begin
               partial_in = {17'd0, req_data_byte[3:0]};
               pending_in = 2'd2;
            end else if (req_data_byte[7:3] == 5'b11110) begin
               partial_in = {18'd0, req_data_byte[2:0]};
               pending_in = 2'd3;
            end else begin
               skip_in = 1'b1;
               job_in.bad = 1'b1;
               count      = 4'd1;
            end
         end else begin
            partial_in = code;
            pending_in = pending_ff - 2'd1;
            if (pending_ff == 2'd1) begin
               partial_in = '0;
               do_emit    = 1'b1;
            end
         end
         if (do_emit) begin
            for (int i = 0; i < ENC_BYTES; i++) begin
               job_in.bytes[i] = enc.bytes[i];
            end
            job_in.bad = enc.bad;
            count      = enc.count;
            if (enc.bad) begin
               skip_in    = 1'b1;
               partial_in = '0;
               pending_in = 2'd0;
            end
         end
         // Put the opening quote in front of whatever this byte produced.
         if (prefix) begin
            for (int i = JOB_BYTES - 1; i > 0; i--) begin
               job_in.bytes[i] = job_in.bytes[i-1];
            end
            job_in.bytes[0] = CH_QUOTE;
            count           = count + 4'd1;
         end
      end
      job_in.last_index = count - 4'd1;
   end

   assign last      = (idx_ff == job_ff.last_index);
   assign rsp_xfer  = busy_ff & rsp_ready;
   assign req_ready = !busy_ff | (rsp_ready & last);
   assign accept    = req_valid & req_ready;
   assign load      = accept & (count != 4'd0);

   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      if (rsp_xfer) begin
         idx_in = idx_ff + 4'd1;
         if (last) begin
            busy_in = 1'b0;
         end
      end
      if (load) begin
         busy_in = 1'b1;
         idx_in  = 4'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         partial_ff <= '0;
         pending_ff <= 2'd0;
         opened_ff  <= 1'b0;
         skip_ff    <= 1'b0;
         busy_ff    <= 1'b0;
         idx_ff     <= 4'd0;
      end else begin
         if (accept) begin
            partial_ff <= partial_in;
            pending_ff <= pending_in;
            opened_ff  <= opened_in;
            skip_ff    <= skip_in;
         end
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         job_ff <= job_in;
      end
   end

   assign rsp_valid         = busy_ff;
   assign rsp_out_byte      = job_ff.bytes[idx_ff];
   assign rsp_run_last      = last;
   assign rsp_bad_utf8      = job_ff.bad & last;
   assign rsp_string_closed = job_ff.closed & last;

`ifndef SYNTHESIS
   // Hold the input while a multi-byte result is still being sent.
   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_run_last) |-> !req_ready)
      else $error("input taken in the middle of a result run");

   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_bad_utf8) |-> (rsp_out_byte == 8'h00 && rsp_run_last))
      else $error("error result carries data or is not last");

   a_close_quote: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_string_closed) |-> (rsp_out_byte == CH_QUOTE && !rsp_bad_utf8))
      else $error("closing flag without a quote byte");

   a_advance: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(idx_ff)))
      else $error("result index moved without a transfer");
`endif

endmodule
